/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

/* rtl/ccf_pkg.sv */
// ----------------------------------------------------------------------------
// ccf_pkg
// types, constants and crc function for the crc32c chunk framer
// ----------------------------------------------------------------------------
package ccf_pkg;

   localparam int unsigned COUNT_W = 21;
   localparam logic [COUNT_W-1:0] MAX_CHUNK_BYTES = COUNT_W'(1048576);
   localparam logic [31:0] CRC_POLY_REFLECTED = 32'h82F6_3B78;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // position of the current result within an item
   localparam logic [2:0] BEAT_DATA = 3'd0;
   localparam logic [2:0] BEAT_CRC3 = 3'd1;
   localparam logic [2:0] BEAT_CRC2 = 3'd2;
   localparam logic [2:0] BEAT_CRC1 = 3'd3;
   localparam logic [2:0] BEAT_CRC0 = 3'd4;

   typedef struct packed {
      logic        close;
      logic [31:0] crc;
   } chunk_info_type;

   function automatic logic [31:0] crc_update_byte(input logic [31:0] crc_val,
                                                   input logic [7:0]  data);
      logic [31:0] c;
      c = crc_val ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/chunked_crc32c_framer.sv */
// ----------------------------------------------------------------------------
// chunked_crc32c_framer
// passes file bytes through and appends a crc32c after each chunk
// output: a byte appears at the result port in the cycle after it is accepted
// throughput: one item per cycle while the result port does not stall; a chunk-closing
// item holds the single result register while it sends its data then four crc bytes
// reset: synchronous, clears the crc to all ones, the count and chunk length
// ----------------------------------------------------------------------------
module chunked_crc32c_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_fragment,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_checksum,
   output logic        rsp_run_last,
   output logic        rsp_fragment_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [20:0] csr_chunk_length
);
   import ccf_pkg::*;

   logic [COUNT_W-1:0] chunk_length_ff;
   logic               can_load;
   logic               accept;
   chunk_info_type     info;

   assign csr_ready = 1'b1;
   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         chunk_length_ff <= csr_chunk_length;
      end
   end

   ccf_crc_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .end_of_fragment (req_end_of_fragment),
      .chunk_length    (chunk_length_ff),
      .info            (info)
   );

   ccf_result_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .load              (accept),
      .data_byte         (req_data_byte),
      .end_of_fragment   (req_end_of_fragment),
      .info              (info),
      .can_load          (can_load),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_checksum   (rsp_is_checksum),
      .rsp_run_last      (rsp_run_last),
      .rsp_fragment_done (rsp_fragment_done)
   );

endmodule

/* rtl/ccf_crc_tracker.sv */
// ----------------------------------------------------------------------------
// ccf_crc_tracker
// running crc32c and chunk byte count, decides where a chunk closes
// ----------------------------------------------------------------------------
module ccf_crc_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic                        end_of_fragment,
   input  logic [ccf_pkg::COUNT_W-1:0] chunk_length,
   output ccf_pkg::chunk_info_type     info
);
   import ccf_pkg::*;

   logic [31:0]        crc_ff, crc_in, crc_upd;
   logic [COUNT_W-1:0] count_ff, count_in, count_upd, limit;
   logic               enabled;

   assign enabled   = (chunk_length != '0);
   assign limit     = (chunk_length > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : chunk_length;
   assign crc_upd   = crc_update_byte(crc_ff, data_byte);
   assign count_upd = count_ff + COUNT_W'(1);

   assign info.close = enabled && (!(count_upd < limit) || end_of_fragment);
   assign info.crc   = ~crc_upd;

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      if (accept) begin
         if (!enabled || info.close) begin
            crc_in   = CRC_INIT;
            count_in = '0;
         end else begin
            crc_in   = crc_upd;
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         count_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/ccf_result_seq.sv */
// ----------------------------------------------------------------------------
// ccf_result_seq
// result register, sends the data byte and then any crc bytes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccf_result_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [7:0]              data_byte,
   input  logic                    end_of_fragment,
   input  ccf_pkg::chunk_info_type info,
   output logic                    can_load,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_is_checksum,
   output logic                    rsp_run_last,
   output logic                    rsp_fragment_done
);
   import ccf_pkg::*;

   logic        valid_ff, valid_in;
   logic [2:0]  beat_ff, beat_in;
   logic [7:0]  byte_ff;
   logic [31:0] crc_ff;
   logic        close_ff;
   logic        eof_ff;
   logic        take;

   assign take     = valid_ff && !rsp_stall;
   assign can_load = !valid_ff || (take && rsp_run_last);

   assign rsp_valid         = valid_ff;
   assign rsp_is_checksum   = (beat_ff != BEAT_DATA);
   assign rsp_run_last      = close_ff ? (beat_ff == BEAT_CRC0) : 1'b1;
   assign rsp_fragment_done = eof_ff && rsp_run_last;

   always_comb begin
      unique case (beat_ff)
         BEAT_DATA: rsp_out_byte = byte_ff;
         BEAT_CRC3: rsp_out_byte = crc_ff[31:24];
         BEAT_CRC2: rsp_out_byte = crc_ff[23:16];
         BEAT_CRC1: rsp_out_byte = crc_ff[15:8];
         BEAT_CRC0: rsp_out_byte = crc_ff[7:0];
         default:   rsp_out_byte = byte_ff;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = BEAT_DATA;
      end else if (take) begin
         if (rsp_run_last) begin
            valid_in = 1'b0;
            beat_in  = BEAT_DATA;
         end else begin
            beat_in  = beat_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= BEAT_DATA;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= data_byte;
         crc_ff   <= info.crc;
         close_ff <= info.close;
         eof_ff   <= end_of_fragment;
      end
   end

   // a taken result that is not the last of its item is always followed by a checksum byte
   `ASSERT_NEXT(a_crc_follows, clock, reset, take && !rsp_run_last, rsp_valid && rsp_is_checksum)
   // fragment end only ever marks the last result of an item
   `ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_valid && rsp_fragment_done, rsp_run_last)
   // a freshly loaded item always starts with its data byte
   `ASSERT_NEXT(a_load_data, clock, reset, load, rsp_valid && !rsp_is_checksum)

endmodule
